// File: rtl/core/wwnp_pkg.sv
// Shared types and constants for the windowed weighted nearest-pose search.
`default_nettype none
package wwnp_pkg;
   localparam int MaxPoseCount = 1024;
   localparam int FeatureCount = 32;
   localparam int WindowSize   = 60;
   localparam int PoseBits     = $clog2(MaxPoseCount);
   localparam int FeatBits     = $clog2(FeatureCount);
   localparam int CountBits    = 11;
   localparam int CostBits     = 38;
   localparam int ElapsedBits  = 21;
   localparam int QueueDepth   = 4;
   localparam int QueueBits    = $clog2(QueueDepth);

   localparam logic [1:0] RegPoseCount = 2'd0;
   localparam logic [1:0] RegMask      = 2'd1;
   localparam logic [1:0] RegPeriod    = 2'd2;

   // One classified item handed from the front to the back.
   typedef struct packed {
      logic                search;
      logic                load;
      logic [PoseBits-1:0] pose_index;
      logic [FeatBits-1:0] feature_index;
      logic [15:0]         feature_value;
      logic [19:0]         delta_time;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_MOD, ST_FETCH, ST_ACCUM, ST_CMP, ST_DONE
   } state_type;
endpackage
`default_nettype wire

// File: rtl/core/wwnp_front.sv
// Input classifier and short item queue between front and back.
`default_nettype none
module wwnp_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic               req_kind,
   input  wire logic [9:0]         req_pose_index,
   input  wire logic [4:0]         req_feature_index,
   input  wire logic signed [15:0] req_feature_value,
   input  wire logic [19:0]        req_delta_time,
   output logic                    item_valid,
   output wwnp_pkg::item_type      item,
   input  wire logic               item_take
);
   import wwnp_pkg::*;
   item_type                 queue_ff [QueueDepth];
   logic [QueueBits-1:0]     wptr_ff, rptr_ff;
   logic [QueueBits:0]       fill_ff;
   item_type                 new_item;
   logic                     push_ok;

   always_comb begin
      new_item.search        = req_kind && (req_feature_index == FeatBits'(FeatureCount-1));
      new_item.load          = !req_kind;
      new_item.pose_index    = req_pose_index;
      new_item.feature_index = req_feature_index;
      new_item.feature_value = req_feature_value;
      new_item.delta_time    = req_delta_time;
   end

   assign req_full   = (fill_ff == (QueueBits+1)'(QueueDepth));
   assign push_ok    = req_push && !req_full;
   assign item_valid = (fill_ff != '0);
   assign item       = queue_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push_ok) queue_ff[wptr_ff] <= new_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push_ok) wptr_ff <= wptr_ff + 1'b1;
         if (item_take) rptr_ff <= rptr_ff + 1'b1;
         fill_ff <= fill_ff + (QueueBits+1)'(push_ok) - (QueueBits+1)'(item_take);
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/wwnp_back.sv
// Feature memory, query store, serial weighted-distance search and blend timer.
`default_nettype none
module wwnp_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    item_valid,
   input  wire wwnp_pkg::item_type      item,
   output logic                         item_take,
   input  wire logic [10:0]             count_cfg,
   input  wire logic [31:0]             weight_mask,
   input  wire logic [19:0]             blend_period,
   output logic                         out_valid,
   input  wire logic                    out_take,
   output logic [9:0]                   best_pose,
   output logic [37:0]                  min_cost,
   output logic [9:0]                   current_pose,
   output logic                         switched
);
   import wwnp_pkg::*;
   localparam int AddrBits = PoseBits + FeatBits;

   logic [15:0]           mem [MaxPoseCount*FeatureCount];
   logic [15:0]           query_ff [FeatureCount];
   logic [15:0]           rd_ff;
   state_type             state_ff, state_in;
   logic [PoseBits:0]     count_ff;
   logic [PoseBits-1:0]   pose_ff, bestp_ff;
   logic [PoseBits-1:0]   rem_ff;
   logic [3:0]            shift_ff;
   logic [10:0]           visit_ff;
   logic [10:0]           window_ff;
   logic [FeatBits-1:0]   feat_ff, feat_d_ff;
   logic                  rdv_ff;
   logic [CostBits-1:0]   acc_ff, bestc_ff;
   logic [19:0]           dt_ff;
   logic [PoseBits-1:0]   cur_ff;
   logic [ElapsedBits-1:0] elapsed_ff;
   logic                  out_valid_ff, sw_ff;
   logic [PoseBits-1:0]   obest_ff, ocur_ff;
   logic [CostBits-1:0]   ocost_ff;
   logic [AddrBits-1:0]   rd_addr;
   logic signed [16:0]    diff;
   logic [15:0]           mag;
   logic [31:0]           prod;
   logic [33:0]           sq;
   logic [PoseBits:0]     eff_count;
   logic [PoseBits:0]     next_pose;
   logic [20:0]           trial;
   logic [PoseBits-1:0]   rem_next;
   logic [ElapsedBits:0]  el_sum;
   logic [ElapsedBits-1:0] el_sat;
   logic                  last_feat;

   always_comb begin
      if (count_cfg == '0) eff_count = (PoseBits+1)'(1);
      else if (count_cfg > 11'(MaxPoseCount)) eff_count = (PoseBits+1)'(MaxPoseCount);
      else eff_count = count_cfg[PoseBits:0];
   end

   // The window start is the current pose modulo the count, found by
   // restoring shift-and-subtract, one bit per cycle.
   assign trial     = 21'(count_ff) << shift_ff;
   assign rem_next  = (21'(rem_ff) >= trial) ? PoseBits'(21'(rem_ff) - trial) : rem_ff;

   assign rd_addr   = {pose_ff, feat_ff};
   assign diff      = $signed({rd_ff[15], rd_ff}) -
                      $signed({query_ff[feat_d_ff][15], query_ff[feat_d_ff]});
   assign mag       = diff[16] ? 16'(-diff) : diff[15:0];
   assign prod      = 32'(mag) * 32'(mag);
   assign sq        = 34'(prod) << weight_mask[feat_d_ff];
   assign next_pose = (PoseBits+1)'(pose_ff) + 1'b1;
   assign el_sum    = (ElapsedBits+1)'(elapsed_ff) + (ElapsedBits+1)'(dt_ff);
   assign el_sat    = el_sum[ElapsedBits] ? '1 : el_sum[ElapsedBits-1:0];
   assign last_feat = (feat_ff == FeatBits'(FeatureCount-1));

   // Loads and query writes retire at once; a search holds the queue head.
   always_comb begin
      state_in  = state_ff;
      item_take = 1'b0;
      case (state_ff)
         ST_IDLE: if (item_valid) begin
            if (item.search) state_in = ST_SETUP;
            else item_take = 1'b1;
         end
         ST_SETUP: state_in = ST_MOD;
         ST_MOD: if (shift_ff == '0) state_in = ST_FETCH;
         ST_FETCH: if (last_feat) state_in = ST_ACCUM;
         ST_ACCUM: state_in = ST_CMP;
         ST_CMP: state_in = (visit_ff + 11'd1 >= window_ff) ? ST_DONE : ST_FETCH;
         ST_DONE: if (!out_valid_ff) begin
            item_take = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && item_valid && item.load)
         mem[{item.pose_index, item.feature_index}] <= item.feature_value;
      if (state_ff == ST_IDLE && item_valid && !item.load)
         query_ff[item.feature_index] <= item.feature_value;
      rd_ff     <= mem[rd_addr];
      feat_d_ff <= feat_ff;
      rdv_ff    <= (state_ff == ST_FETCH);
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_SETUP: begin
            count_ff  <= eff_count;
            window_ff <= (eff_count < (PoseBits+1)'(WindowSize)) ? 11'(eff_count)
                                                                   : 11'(WindowSize);
            rem_ff    <= cur_ff;
            shift_ff  <= 4'(PoseBits - 1);
            visit_ff  <= '0;
            feat_ff   <= '0;
            acc_ff    <= '0;
            dt_ff     <= item.delta_time;
         end
         ST_MOD: begin
            rem_ff   <= rem_next;
            pose_ff  <= rem_next;
            shift_ff <= shift_ff - 4'd1;
         end
         ST_FETCH: feat_ff <= feat_ff + 1'b1;
         ST_CMP: begin
            if (visit_ff == '0 || acc_ff < bestc_ff) begin
               bestc_ff <= acc_ff;
               bestp_ff <= pose_ff;
            end
            acc_ff   <= '0;
            visit_ff <= visit_ff + 11'd1;
            pose_ff  <= (next_pose >= count_ff) ? '0 : next_pose[PoseBits-1:0];
         end
         default: ;
      endcase
      if (rdv_ff) acc_ff <= acc_ff + CostBits'(sq);
      if (state_ff == ST_DONE && !out_valid_ff) begin
         obest_ff <= bestp_ff;
         ocost_ff <= bestc_ff;
         ocur_ff  <= (el_sat >= ElapsedBits'(blend_period)) ? bestp_ff : cur_ff;
         sw_ff    <= (el_sat >= ElapsedBits'(blend_period)) && (bestp_ff != cur_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         elapsed_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && !out_valid_ff) begin
            out_valid_ff <= 1'b1;
            if (el_sat >= ElapsedBits'(blend_period)) begin
               cur_ff     <= bestp_ff;
               elapsed_ff <= '0;
            end else begin
               elapsed_ff <= el_sat;
            end
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid    = out_valid_ff;
   assign best_pose    = obest_ff;
   assign min_cost     = ocost_ff;
   assign current_pose = ocur_ff;
   assign switched     = sw_ff;
endmodule
`default_nettype wire

// File: rtl/core/windowed_weighted_nearest_pose.sv
// Top level of the windowed weighted nearest-pose search.
// Input items enter through req_push/req_full into a four-entry queue.
// A load item writes one feature of one pose; a query item stores one
// query feature. The query item for the last feature starts a search over
// min(60, pose count register clamped to 1..1024) poses from the current
// pose modulo the count. The window start is found first, then each pose
// is scored one feature per cycle through a single multiply-accumulate;
// other items retire straight from the queue head.
// The result waits in an output register shown by rsp_empty low and taken
// with rsp_pop; while it waits, items still queue until the queue is full,
// and the next search finishes but holds its result until the slot frees.
// Configuration is written through the APB port; the user must write it
// only while idle, as the block itself does not enforce this.
// Reset (synchronous, active high) empties queue and output, clears the
// current pose and blend timer and loads the register defaults. Feature
// memory is not cleared; unwritten entries read undefined.
`default_nettype none
module windowed_weighted_nearest_pose (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic               req_kind,
   input  wire logic [9:0]         req_pose_index,
   input  wire logic [4:0]         req_feature_index,
   input  wire logic signed [15:0] req_feature_value,
   input  wire logic [19:0]        req_delta_time,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [9:0]              rsp_best_pose,
   output logic [37:0]             rsp_min_cost,
   output logic [9:0]              rsp_current_pose,
   output logic                    rsp_switched,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import wwnp_pkg::*;
   logic [10:0] count_ff;
   logic [31:0] mask_ff;
   logic [19:0] period_ff;
   logic        item_valid, item_take, out_valid, wr;
   item_type    item;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 11'd1024;
         mask_ff   <= 32'd2097144;
         period_ff <= 20'd100000;
      end else if (wr && paddr[1:0] == 2'b00) begin
         case (paddr[3:2])
            RegPoseCount: count_ff  <= pwdata[10:0];
            RegMask:      mask_ff   <= pwdata;
            RegPeriod:    period_ff <= pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         RegPoseCount: prdata = {21'd0, count_ff};
         RegMask:      prdata = mask_ff;
         RegPeriod:    prdata = {12'd0, period_ff};
         default:      prdata = '0;
      endcase
   end

   wwnp_front u_front (
      .clock, .reset, .req_push, .req_full, .req_kind, .req_pose_index,
      .req_feature_index, .req_feature_value, .req_delta_time,
      .item_valid, .item, .item_take
   );

   wwnp_back u_back (
      .clock, .reset, .item_valid, .item, .item_take,
      .count_cfg(count_ff), .weight_mask(mask_ff), .blend_period(period_ff),
      .out_valid, .out_take(rsp_pop),
      .best_pose(rsp_best_pose), .min_cost(rsp_min_cost),
      .current_pose(rsp_current_pose), .switched(rsp_switched)
   );

   assign rsp_empty = !out_valid;

   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      item_take |-> item_valid) else $error("queue read while empty");
   a_switch_changes: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_switched) |-> (rsp_best_pose == rsp_current_pose))
      else $error("switch without commit");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty) else $error("result dropped");
endmodule
`default_nettype wire

// File: verif/windowed_weighted_nearest_pose_test.sv
// Testbench for the windowed weighted nearest-pose search.
`timescale 1ns / 1ps
module windowed_weighted_nearest_pose_test;
   import wwnp_pkg::*;

   typedef struct {
      logic [9:0]  best_pose;
      logic [37:0] cost;
      logic [9:0]  current_pose;
      logic        switched;
   } match_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic               req_kind = 1'b0;
   logic [9:0]         req_pose_index = '0;
   logic [4:0]         req_feature_index = '0;
   logic signed [15:0] req_feature_value = '0;
   logic [19:0]        req_delta_time = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [9:0]         rsp_best_pose;
   logic [37:0]        rsp_min_cost;
   logic [9:0]         rsp_current_pose;
   logic               rsp_switched;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   // Predictor state.
   logic [15:0] pose_mem [MaxPoseCount][FeatureCount];
   logic [15:0] query_mem [FeatureCount];
   logic [9:0]  cur_pose;
   logic [20:0] blend_timer;
   logic [10:0] count_reg;
   logic [31:0] double_mask_reg;
   logic [19:0] period_reg;

   match_type pending_matches [$];
   int        error_count = 0;
   int        items_sent = 0;
   int        matches_checked = 0;
   int        switch_count = 0;
   int        send_idle_pct = 0;
   int        pop_stall_pct = 0;

   windowed_weighted_nearest_pose u_top (.*);

   always #2 clock = ~clock;

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [37:0] pose_distance(int pose);
      logic [37:0] sum;
      int          diff;
      logic [37:0] sq;
      sum = '0;
      for (int f = 0; f < FeatureCount; f++) begin
         diff = $signed(pose_mem[pose][f]) - $signed(query_mem[f]);
         sq = 38'(longint'(diff) * longint'(diff));
         if (f < 32 && double_mask_reg[f]) sq = sq << 1;
         sum += sq;
      end
      return sum;
   endfunction

   task automatic predict_item(logic kind, logic [9:0] pidx, logic [4:0] fidx,
                               logic [15:0] fval, logic [19:0] dt);
      int          count;
      int          span;
      int          start;
      int          p;
      logic [37:0] c;
      match_type   m;
      logic [9:0]  old_pose;
      logic [21:0] timer_sum;
      if (kind == 1'b0) begin
         pose_mem[pidx][fidx] = fval;
         return;
      end
      query_mem[fidx] = fval;
      if (fidx != FeatureCount - 1) return;
      count = count_reg;
      if (count < 1) count = 1;
      if (count > MaxPoseCount) count = MaxPoseCount;
      span = (WindowSize < count) ? WindowSize : count;
      start = cur_pose % count;
      m.best_pose = 10'(start);
      m.cost = pose_distance(start);
      for (int k = 1; k < span; k++) begin
         p = (start + k) % count;
         c = pose_distance(p);
         if (c < m.cost) begin
            m.cost = c;
            m.best_pose = 10'(p);
         end
      end
      timer_sum = blend_timer + dt;
      blend_timer = (timer_sum > 22'h1FFFFF) ? 21'h1FFFFF : timer_sum[20:0];
      m.switched = 1'b0;
      if (blend_timer >= period_reg) begin
         old_pose = cur_pose;
         cur_pose = m.best_pose;
         blend_timer = '0;
         m.switched = (old_pose != cur_pose);
      end
      m.current_pose = cur_pose;
      pending_matches.push_back(m);
   endtask

   // Result side: compare each transfer, then decide the next stall.
   always @(posedge clock) begin
      match_type m;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_matches.size() == 0) begin
            $error("result transfer with no expected result");
            error_count++;
         end else begin
            m = pending_matches.pop_front();
            matches_checked++;
            if (rsp_switched) switch_count++;
            if (rsp_best_pose !== m.best_pose) begin
               $error("best_pose: expected %0d, actual %0d", m.best_pose, rsp_best_pose);
               error_count++;
            end
            if (rsp_min_cost !== m.cost) begin
               $error("min_cost: expected %0d, actual %0d", m.cost, rsp_min_cost);
               error_count++;
            end
            if (rsp_current_pose !== m.current_pose) begin
               $error("current_pose: expected %0d, actual %0d",
                      m.current_pose, rsp_current_pose);
               error_count++;
            end
            if (rsp_switched !== m.switched) begin
               $error("switched: expected %0d, actual %0d", m.switched, rsp_switched);
               error_count++;
            end
         end
      end
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   // Called just after a rising edge; returns just after the accepting edge.
   task automatic send_item(logic kind, logic [9:0] pidx, logic [4:0] fidx,
                            logic [15:0] fval, logic [19:0] dt);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_push <= 1'b1;
      req_kind <= kind;
      req_pose_index <= pidx;
      req_feature_index <= fidx;
      req_feature_value <= fval;
      req_delta_time <= dt;
      do @(posedge clock); while (req_full);
      predict_item(kind, pidx, fidx, fval, dt);
      items_sent++;
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      // Give loads and partial queries still in the queue time to retire.
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         RegPoseCount: count_reg = value[10:0];
         RegMask:      double_mask_reg = value;
         RegPeriod:    period_reg = value[19:0];
         default: ;
      endcase
   endtask

   task automatic configure(int count, logic [31:0] mask, int period);
      drain_results();
      write_reg(RegPoseCount, 32'(count));
      write_reg(RegMask, mask);
      write_reg(RegPeriod, 32'(period));
   endtask

   task automatic load_pose(int pose, logic [15:0] fill, bit random_fill);
      for (int f = 0; f < FeatureCount; f++)
         send_item(1'b0, 10'(pose), 5'(f), random_fill ? 16'($urandom) : fill,
                   20'd0);
   endtask

   task automatic send_query(logic [15:0] fill, bit random_fill, logic [19:0] dt);
      for (int f = 0; f < FeatureCount; f++)
         send_item(1'b1, 10'd0, 5'(f), random_fill ? 16'($urandom) : fill, dt);
   endtask

   // Feature extremes, ties, zero period, count of zero and timer extremes.
   task automatic test_directed();
      configure(4, 32'h0, 0);
      load_pose(0, 16'h7FFF, 0);
      load_pose(1, 16'h8000, 0);
      load_pose(2, 16'h0000, 0);
      load_pose(3, 16'h0000, 0);
      send_query(16'h7FFF, 0, 20'd0);
      send_query(16'h8000, 0, 20'd0);
      // Poses two and three are equal, so the earlier one must win.
      send_query(16'h0001, 0, 20'd0);
      configure(4, 32'hFFFF_FFFF, 1000000);
      send_query(16'h7FFF, 0, 20'd0);
      send_item(1'b1, 10'h3FF, 5'd31, 16'h8000, 20'd1000000);
      send_item(1'b1, 10'h155, 5'd31, 16'h8000, 20'd999999);
      send_item(1'b1, 10'h2AA, 5'd31, 16'h8000, 20'd1000000);
      configure(0, 32'h5555_AAAA, 1);
      send_item(1'b1, 10'd0, 5'd31, 16'h1234, 20'd1);
      send_item(1'b1, 10'd0, 5'd31, 16'h1234, 20'd0);
   endtask

   // Window wrap: poses four to eleven written for a count of twelve, then a count of seven.
   task automatic test_window_wrap();
      configure(1, 32'h001F_FFF8, 100000);
      for (int p = 4; p < 12; p++) load_pose(p, 16'h0, 1);
      configure(12, 32'h001F_FFF8, 100000);
      send_query(16'h0, 1, 20'd60000);
      send_item(1'b1, 10'd0, 5'd31, 16'($urandom), 20'd60000);
      configure(7, 32'($urandom), 1);
      send_item(1'b1, 10'd0, 5'd31, 16'($urandom), 20'd5);
      send_item(1'b1, 10'd0, 5'd31, 16'($urandom), 20'd0);
   endtask

   task automatic test_random_phase(int idle_pct, int stall_pct, int n, bit hold_off);
      logic        kind;
      logic [4:0]  fidx;
      logic [19:0] dt;
      configure($urandom_range(12, 1), 32'($urandom), $urandom_range(2000, 1));
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      for (int i = 0; i < n; i++) begin
         kind = ($urandom_range(99) < 55);
         fidx = ($urandom_range(99) < 12) ? 5'd31 : 5'($urandom);
         case ($urandom_range(9))
            0:       dt = 20'd0;
            1:       dt = 20'd1000000;
            default: dt = 20'($urandom_range(1500));
         endcase
         send_item(kind, 10'($urandom), fidx,
                   ($urandom_range(9) == 0) ?
                      (($urandom_range(1) == 0) ? 16'h7FFF : 16'h8000)
                      : 16'($urandom), dt);
         if (hold_off && i == n / 2) begin
            req_push <= 1'b0;
            while (pending_matches.size() != 0) @(posedge clock);
         end
      end
      send_idle_pct = 0;
      pop_stall_pct = 0;
   endtask

   initial begin
      for (int p = 0; p < MaxPoseCount; p++)
         for (int f = 0; f < FeatureCount; f++) pose_mem[p][f] = '0;
      for (int f = 0; f < FeatureCount; f++) query_mem[f] = '0;
      cur_pose = '0;
      blend_timer = '0;
      count_reg = 11'd1024;
      double_mask_reg = 32'h001F_FFF8;
      period_reg = 20'd100000;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_window_wrap();
      test_random_phase(0, 0, 100, 0);
      test_random_phase(72, 0, 100, 1);
      test_random_phase(0, 72, 100, 0);
      test_random_phase(15, 15, 100, 0);
      drain_results();
      $display("Covered %0d input transfers and %0d checked results (%0d pose switches),",
               items_sent, matches_checked, switch_count);
      $display("over several count, mask and period settings and idle patterns.");
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
